// ===== rtl/mcft_pkg.sv =====
package mcft_pkg;

  // Width of every run length counter; counters saturate at the top value.
  localparam int unsigned RUN_BITS = 8;
  localparam logic [RUN_BITS-1:0] RunMax = {RUN_BITS{1'b1}};
  localparam logic [RUN_BITS-1:0] MinFence = RUN_BITS'(3);

  localparam logic [7:0] ChTick  = 8'h60;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChWsLo  = 8'h09;
  localparam logic [7:0] ChWsHi  = 8'h0D;

  // Depth of the queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [1:0] MaxLeadSpaces = 2'd3;

  typedef enum logic [1:0] {
    RC_NONE  = 2'd0,
    RC_TICK  = 2'd1,
    RC_TILDE = 2'd2
  } run_char_e;

  typedef enum logic {
    OP_FEED  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    logic       op;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic fence_open;
    logic inline_code;
  } out_item_t;

  // Classified item as it travels from front to back.
  typedef struct packed {
    logic clear;
    logic newline;
    logic tick;
    logic tilde;
    logic space;
    logic ws;
  } class_t;

  function automatic logic [RUN_BITS-1:0] sat_inc(input logic [RUN_BITS-1:0] v);
    sat_inc = (v == RunMax) ? v : v + RUN_BITS'(1);
  endfunction

endpackage

// ===== rtl/mcft_front.sv =====
module mcft_front (
  input  mcft_pkg::in_item_t in_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output mcft_pkg::class_t   q_data_o
);

  logic [7:0] c;

  assign c = in_data_i.char_byte;

  always_comb begin
    q_data_o.clear   = (in_data_i.op == mcft_pkg::OP_CLEAR);
    q_data_o.newline = (c == mcft_pkg::ChNl);
    q_data_o.tick    = (c == mcft_pkg::ChTick);
    q_data_o.tilde   = (c == mcft_pkg::ChTilde);
    q_data_o.space   = (c == mcft_pkg::ChSpace);
    q_data_o.ws      = ((c >= mcft_pkg::ChWsLo) && (c <= mcft_pkg::ChWsHi)) ||
                       (c == mcft_pkg::ChSpace);
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// ===== rtl/mcft_queue.sv =====
module mcft_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mcft_pkg::class_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mcft_pkg::class_t pop_data_o
);

  mcft_pkg::class_t                 mem_q [mcft_pkg::QDepth];
  logic [mcft_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [mcft_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [mcft_pkg::QCntW-1:0]       cnt_q, cnt_d;

  assign full_o     = (cnt_q == mcft_pkg::QCntW'(mcft_pkg::QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + mcft_pkg::QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + mcft_pkg::QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + mcft_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - mcft_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/mcft_back.sv =====
module mcft_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  mcft_pkg::class_t    q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mcft_pkg::out_item_t out_data_o
);

  localparam int unsigned RB = mcft_pkg::RUN_BITS;

  logic                 inside_fence_q, inside_fence_d;
  mcft_pkg::run_char_e  open_char_q, open_char_d;
  logic [RB-1:0]        open_len_q, open_len_d;
  logic [1:0]           lead_cnt_q, lead_cnt_d;
  logic                 prefix_q, prefix_d;
  logic                 run_active_q, run_active_d;
  mcft_pkg::run_char_e  run_char_q, run_char_d;
  logic [RB-1:0]        run_len_q, run_len_d;
  logic                 opens_fence_q, opens_fence_d;
  logic                 text_after_q, text_after_d;
  logic [RB-1:0]        tick_len_q, tick_len_d;
  logic                 tick_start_q, tick_start_d;
  logic [RB-1:0]        inl_len_q, inl_len_d;

  logic                 out_valid_q;
  mcft_pkg::out_item_t  out_data_q, out_data_d;

  logic                 run_match;
  logic                 cand_q;
  logic                 cand_d;
  logic                 inline_d;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // Byte continues the leading run of this line.
  assign run_match = ((run_char_q == mcft_pkg::RC_TICK) && q_data_i.tick) ||
                     ((run_char_q == mcft_pkg::RC_TILDE) && q_data_i.tilde);

  assign cand_q = tick_start_q && (tick_len_q >= mcft_pkg::MinFence);

  always_comb begin
    inside_fence_d = inside_fence_q;
    open_char_d    = open_char_q;
    open_len_d     = open_len_q;
    lead_cnt_d     = lead_cnt_q;
    prefix_d       = prefix_q;
    run_active_d   = run_active_q;
    run_char_d     = run_char_q;
    run_len_d      = run_len_q;
    opens_fence_d  = opens_fence_q;
    text_after_d   = text_after_q;
    tick_len_d     = tick_len_q;
    tick_start_d   = tick_start_q;
    inl_len_d      = inl_len_q;

    if (q_data_i.clear || q_data_i.newline) begin
      if (q_data_i.clear) begin
        inside_fence_d = 1'b0;
        open_char_d    = mcft_pkg::RC_NONE;
        open_len_d     = '0;
      end else if (!inside_fence_q) begin
        if (opens_fence_q) begin
          inside_fence_d = 1'b1;
          open_char_d    = run_char_q;
          open_len_d     = run_len_q;
        end
      end else if ((run_char_q == open_char_q) && (run_len_q >= open_len_q) &&
                   !text_after_q) begin
        inside_fence_d = 1'b0;
        open_char_d    = mcft_pkg::RC_NONE;
        open_len_d     = '0;
      end
      lead_cnt_d    = '0;
      prefix_d      = 1'b1;
      run_active_d  = 1'b0;
      run_char_d    = mcft_pkg::RC_NONE;
      run_len_d     = '0;
      opens_fence_d = 1'b0;
      text_after_d  = 1'b0;
      tick_len_d    = '0;
      tick_start_d  = 1'b0;
      inl_len_d     = '0;
    end else begin
      // Inline backtick tracking, frozen inside a fence.
      if (!inside_fence_q) begin
        if (q_data_i.tick) begin
          if (tick_len_q == '0) begin
            tick_start_d = prefix_q;
          end
          tick_len_d = mcft_pkg::sat_inc(tick_len_q);
        end else if (tick_len_q != '0) begin
          if (!cand_q) begin
            if (inl_len_q == '0) begin
              inl_len_d = tick_len_q;
            end else if (tick_len_q == inl_len_q) begin
              inl_len_d = '0;
            end
          end
          tick_len_d   = '0;
          tick_start_d = 1'b0;
        end
      end

      // Line prefix and leading fence run.
      if (run_active_q) begin
        if (run_match) begin
          run_len_d = mcft_pkg::sat_inc(run_len_q);
          if (!inside_fence_q && (run_len_d >= mcft_pkg::MinFence)) begin
            opens_fence_d = 1'b1;
          end
        end else begin
          run_active_d = 1'b0;
          if (!q_data_i.ws) begin
            text_after_d = 1'b1;
          end
        end
      end else if (!prefix_q) begin
        if (!q_data_i.ws) begin
          text_after_d = 1'b1;
        end
      end else if (q_data_i.space && (lead_cnt_q < mcft_pkg::MaxLeadSpaces)) begin
        lead_cnt_d = lead_cnt_q + 2'd1;
      end else begin
        prefix_d = 1'b0;
        if (q_data_i.tick || q_data_i.tilde) begin
          run_active_d = 1'b1;
          run_char_d   = q_data_i.tick ? mcft_pkg::RC_TICK : mcft_pkg::RC_TILDE;
          run_len_d    = RB'(1);
        end else if (!q_data_i.ws) begin
          text_after_d = 1'b1;
        end
      end
    end
  end

  // Inline view after this item; a pending tick run is judged as if closed.
  always_comb begin
    cand_d = tick_start_d && (tick_len_d >= mcft_pkg::MinFence);
    if (inside_fence_d) begin
      inline_d = 1'b0;
    end else if ((tick_len_d == '0) || cand_d) begin
      inline_d = (inl_len_d != '0);
    end else if (inl_len_d == '0) begin
      inline_d = 1'b1;
    end else begin
      inline_d = (tick_len_d != inl_len_d);
    end
    out_data_d.fence_open  = inside_fence_d;
    out_data_d.inline_code = inline_d;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_fence_q <= 1'b0;
      open_char_q    <= mcft_pkg::RC_NONE;
      open_len_q     <= '0;
      lead_cnt_q     <= '0;
      prefix_q       <= 1'b1;
      run_active_q   <= 1'b0;
      run_char_q     <= mcft_pkg::RC_NONE;
      run_len_q      <= '0;
      opens_fence_q  <= 1'b0;
      text_after_q   <= 1'b0;
      tick_len_q     <= '0;
      tick_start_q   <= 1'b0;
      inl_len_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (q_pop_o) begin
        inside_fence_q <= inside_fence_d;
        open_char_q    <= open_char_d;
        open_len_q     <= open_len_d;
        lead_cnt_q     <= lead_cnt_d;
        prefix_q       <= prefix_d;
        run_active_q   <= run_active_d;
        run_char_q     <= run_char_d;
        run_len_q      <= run_len_d;
        opens_fence_q  <= opens_fence_d;
        text_after_q   <= text_after_d;
        tick_len_q     <= tick_len_d;
        tick_start_q   <= tick_start_d;
        inl_len_q      <= inl_len_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/markdown_code_fence_tracker.sv =====
// Channel | Dir | Handshake               | Payload
// in      | in  | in_valid_i / in_ready_o | in_data_i  (op, char_byte)
// out     | out | out_valid_o/out_ready_i | out_data_o (fence_open, inline_code)
//
// One transfer in, one transfer out per item; one item per cycle sustained
// while out_ready_i stays high. Each item is classified into a two-entry
// queue, then the state update in the back end writes the output register.
// Reset (rst_ni low, async) clears all tracking state; same as a clear op.
// in_ready_o drops only when the queue is full, i.e. it holds two items
// while a result waits on out_ready_i; in steady streaming one item already
// waits in the queue, so one more arrival while the output is stalled fills
// it. The back end keeps popping while the output is free or taken.
module markdown_code_fence_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mcft_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mcft_pkg::out_item_t out_data_o
);

  // Front to queue
  logic             q_push;
  logic             q_full;
  mcft_pkg::class_t q_wdata;

  // Queue to back
  logic             q_pop;
  logic             q_valid;
  mcft_pkg::class_t q_rdata;

  // Byte classification: clear, newline, tick, tilde, space, whitespace.
  mcft_front u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // Decouples intake from the result side.
  mcft_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  // Fence / inline span state and the registered result.
  mcft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
